// ===== sv/bucketed_window_rate_meter_defines.svh =====
// Assertion macros for the rate meter.
`ifndef BUCKETED_WINDOW_RATE_METER_DEFINES_SVH
`define BUCKETED_WINDOW_RATE_METER_DEFINES_SVH
`ifndef SYNTHESIS
`define BWRM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rate meter assertion failed");
`define BWRM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rate meter assertion failed");
`else
`define BWRM_ASSERT_SAME(lbl, ante, cons)
`define BWRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/bwrm_pkg.sv =====
package bwrm_pkg;

   localparam int unsigned MAX_BUCKETS_DEF = 64;

   localparam int unsigned TIME_W     = 48;
   localparam int unsigned INTERVAL_W = 16;
   localparam int unsigned ACTIVE_W   = 7;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned WCOUNT_W   = 38;
   localparam int unsigned RATE_W     = 48;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 88;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - WCOUNT_W - RATE_W;

   localparam int unsigned MS_PER_SEC = 1000;
   localparam int unsigned SCALE_W    = 10;
   localparam int unsigned FRAC_BITS  = 8;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd100;
   localparam logic [ACTIVE_W-1:0]   ACTIVE_RST   = 7'd10;

   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE   = 2'd1;

   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DSEL_TIME = 2'd0;
   localparam div_sel_type DSEL_SLOT = 2'd1;
   localparam div_sel_type DSEL_RATE = 2'd2;

   typedef struct packed {
      logic        load_req;
      logic        div_start;
      div_sel_type div_sel;
      logic        id_load;
      logic        slot_load;
      logic        mem_read;
      logic        mem_write;
      logic        scan_clear;
      logic        scan_step;
      logic        prod_load;
      logic        rate_load;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic div_done;
      logic scan_done;
      logic rsp_busy;
   } sts_type;

   function automatic int unsigned idx_w(int unsigned mb);
      return $clog2(mb);
   endfunction

   function automatic int unsigned act_w(int unsigned mb);
      return $clog2(mb + 1);
   endfunction

   function automatic int unsigned sum_w(int unsigned mb);
      return COUNT_W + idx_w(mb);
   endfunction

   function automatic int unsigned num_w(int unsigned mb);
      return sum_w(mb) + SCALE_W + FRAC_BITS;
   endfunction

   function automatic int unsigned dvd_w(int unsigned mb);
      return (num_w(mb) > TIME_W) ? num_w(mb) : TIME_W;
   endfunction

   function automatic int unsigned dvs_w(int unsigned mb);
      return INTERVAL_W + act_w(mb);
   endfunction

endpackage

// ===== sv/bwrm_div.sv =====
module bwrm_div
   import bwrm_pkg::*;
#(
   parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dvd_w(MAX_BUCKETS)-1:0]     dividend,
   input  logic [dvs_w(MAX_BUCKETS)-1:0]     divisor,
   output logic [dvd_w(MAX_BUCKETS)-1:0]     quotient,
   output logic [dvs_w(MAX_BUCKETS)-1:0]     remainder,
   output logic                              done
);

   localparam int unsigned DVW   = dvd_w(MAX_BUCKETS);
   localparam int unsigned DSW   = dvs_w(MAX_BUCKETS);
   localparam int unsigned CNT_W = $clog2(DVW);

   logic [DVW-1:0]   quo_ff, quo_in;
   logic [DSW-1:0]   rem_ff, rem_in;
   logic [DSW-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSW:0]     rem_sh;
   logic [DSW:0]     diff;
   logic             ge;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVW-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVW-2:0], ge};
         rem_in = ge ? diff[DSW-1:0] : rem_sh[DSW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== sv/bwrm_ctrl.sv =====
module bwrm_ctrl
   import bwrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV_ID   = 4'd1;
   localparam logic [3:0] S_DIV_SLOT = 4'd2;
   localparam logic [3:0] S_RD       = 4'd3;
   localparam logic [3:0] S_UPD      = 4'd4;
   localparam logic [3:0] S_SCAN     = 4'd5;
   localparam logic [3:0] S_MUL      = 4'd6;
   localparam logic [3:0] S_RSTART   = 4'd7;
   localparam logic [3:0] S_DIV_RATE = 4'd8;
   localparam logic [3:0] S_OUT      = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_TIME;
               state_in      = S_DIV_ID;
            end
         end
         S_DIV_ID: begin
            if (sts.div_done) begin
               cmd.id_load = 1'b1;
               if (sts.is_query) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DSEL_SLOT;
                  state_in      = S_DIV_SLOT;
               end
            end
         end
         S_DIV_SLOT: begin
            if (sts.div_done) begin
               cmd.slot_load = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_UPD;
         end
         S_UPD: begin
            cmd.mem_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.prod_load = 1'b1;
            state_in      = S_RSTART;
         end
         S_RSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_RATE;
            state_in      = S_DIV_RATE;
         end
         S_DIV_RATE: begin
            if (sts.div_done) begin
               cmd.rate_load = 1'b1;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/bwrm_dpath.sv =====
module bwrm_dpath
   import bwrm_pkg::*;
#(
   parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [INTERVAL_W-1:0] csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned IDX_W  = idx_w(MAX_BUCKETS);
   localparam int unsigned CNTA_W = act_w(MAX_BUCKETS);
   localparam int unsigned SUM_W  = sum_w(MAX_BUCKETS);
   localparam int unsigned PROD_W = SUM_W + SCALE_W;
   localparam int unsigned NUM_W  = num_w(MAX_BUCKETS);
   localparam int unsigned DVW    = dvd_w(MAX_BUCKETS);
   localparam int unsigned DSW    = dvs_w(MAX_BUCKETS);

   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [ACTIVE_W-1:0]   active_ff, active_in;
   logic                  type_ff, type_in;
   logic [TIME_W-1:0]     id_ff, id_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [CNTA_W-1:0]     idx_ff, idx_in;
   logic                  acc_pend_ff, acc_pend_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DSW-1:0]        window_ff, window_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [WCOUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [RATE_W-1:0]     rsp_rate_ff, rsp_rate_in;
   logic [MAX_BUCKETS-1:0] valid_ff, valid_in;
   logic [TIME_W-1:0]     rd_tag_ff;
   logic [COUNT_W-1:0]    rd_cnt_ff;
   logic                  rd_valid_ff;

   logic [TIME_W-1:0]     tag_mem [MAX_BUCKETS];
   logic [COUNT_W-1:0]    cnt_mem [MAX_BUCKETS];

   logic [INTERVAL_W-1:0] eff_interval;
   logic [CNTA_W-1:0]     eff_active;
   logic [DVW-1:0]        dividend;
   logic [DSW-1:0]        divisor;
   logic [DVW-1:0]        quotient;
   logic [DSW-1:0]        remainder;
   logic                  div_done;
   logic                  scan_issue;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [TIME_W-1:0]     tag_eff;
   logic [COUNT_W-1:0]    cnt_eff;
   logic                  in_window;
   logic                  hit;
   logic [COUNT_W-1:0]    wr_cnt;
   logic [NUM_W-1:0]      numerator;

   always_comb begin
      eff_interval = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;
      if (active_ff == '0) begin
         eff_active = CNTA_W'(1);
      end else if (32'(active_ff) > 32'(MAX_BUCKETS)) begin
         eff_active = CNTA_W'(MAX_BUCKETS);
      end else begin
         eff_active = CNTA_W'(active_ff);
      end
   end

   assign numerator = {prod_ff, {FRAC_BITS{1'b0}}};

   always_comb begin
      unique case (cmd.div_sel)
         DSEL_TIME: begin
            dividend = DVW'(req_tdata[TIME_W-1:0]);
            divisor  = DSW'(eff_interval);
         end
         DSEL_SLOT: begin
            dividend = DVW'(quotient[TIME_W-1:0]);
            divisor  = DSW'(eff_active);
         end
         DSEL_RATE: begin
            dividend = DVW'(numerator);
            divisor  = window_ff;
         end
         default: begin
            dividend = DVW'(req_tdata[TIME_W-1:0]);
            divisor  = DSW'(eff_interval);
         end
      endcase
   end

   bwrm_div #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .quotient  (quotient),
      .remainder (remainder),
      .done      (div_done)
   );

   // Slots that were never written read as tag zero, count zero.
   always_comb begin
      scan_issue = cmd.scan_step && (idx_ff < eff_active);
      rd_en      = cmd.mem_read || scan_issue;
      rd_addr    = cmd.scan_step ? idx_ff[IDX_W-1:0] : slot_ff;
      tag_eff    = rd_valid_ff ? rd_tag_ff : '0;
      cnt_eff    = rd_valid_ff ? rd_cnt_ff : '0;
      in_window  = (tag_eff <= id_ff) && ((id_ff - tag_eff) < TIME_W'(eff_active));
      hit        = tag_eff == id_ff;
      if (!hit) begin
         wr_cnt = COUNT_W'(1);
      end else if (cnt_eff == '1) begin
         wr_cnt = cnt_eff;
      end else begin
         wr_cnt = cnt_eff + COUNT_W'(1);
      end
   end

   always_comb begin
      interval_in  = interval_ff;
      active_in    = active_ff;
      type_in      = cmd.load_req ? req_tuser : type_ff;
      id_in        = cmd.id_load ? quotient[TIME_W-1:0] : id_ff;
      slot_in      = cmd.slot_load ? remainder[IDX_W-1:0] : slot_ff;
      acc_pend_in  = scan_issue;
      prod_in      = cmd.prod_load ? PROD_W'(sum_ff) * PROD_W'(MS_PER_SEC) : prod_ff;
      window_in    = cmd.prod_load ? DSW'(eff_active) * DSW'(eff_interval) : window_ff;
      rsp_count_in = cmd.out_load ? WCOUNT_W'(sum_ff) : rsp_count_ff;
      rsp_rate_in  = cmd.out_load ? rate_ff : rsp_rate_ff;
      valid_in     = valid_ff;
      if (csr_valid) begin
         if (csr_index == REG_INTERVAL) begin
            interval_in = csr_data;
         end else if (csr_index == REG_ACTIVE) begin
            active_in = csr_data[ACTIVE_W-1:0];
         end
      end
      if (cmd.scan_clear) begin
         idx_in = '0;
      end else if (scan_issue) begin
         idx_in = idx_ff + CNTA_W'(1);
      end else begin
         idx_in = idx_ff;
      end
      if (cmd.scan_clear) begin
         sum_in = '0;
      end else if (acc_pend_ff && in_window) begin
         sum_in = sum_ff + SUM_W'(cnt_eff);
      end else begin
         sum_in = sum_ff;
      end
      if (!cmd.rate_load) begin
         rate_in = rate_ff;
      end else if (|quotient[DVW-1:RATE_W]) begin
         rate_in = '1;
      end else begin
         rate_in = quotient[RATE_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
      if (cmd.mem_write) begin
         valid_in[slot_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RST;
         active_ff   <= ACTIVE_RST;
         idx_ff      <= '0;
         acc_pend_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         valid_ff    <= '0;
      end else begin
         interval_ff <= interval_in;
         active_ff   <= active_in;
         idx_ff      <= idx_in;
         acc_pend_ff <= acc_pend_in;
         rsp_vld_ff  <= rsp_vld_in;
         valid_ff    <= valid_in;
      end
      type_ff      <= type_in;
      id_ff        <= id_in;
      slot_ff      <= slot_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      window_ff    <= window_in;
      rate_ff      <= rate_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rate_ff  <= rsp_rate_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         tag_mem[slot_ff] <= id_ff;
         cnt_mem[slot_ff] <= wr_cnt;
      end
      if (rd_en) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_cnt_ff   <= cnt_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign sts.is_query  = type_ff == REQ_QUERY;
   assign sts.div_done  = div_done;
   assign sts.scan_done = (idx_ff == eff_active) && !acc_pend_ff;
   assign sts.rsp_busy  = rsp_vld_ff && !rsp_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_rate_ff, rsp_count_ff};

endmodule

// ===== sv/bucketed_window_rate_meter.sv =====
// One request word is handled at a time; the next is accepted once the current one is done.
// Record: two passes through the bit-serial divider (bucket id, then slot index), then a
// read-modify-write of the slot.
// Query: two divider passes (bucket id, then rate) around a one-slot-per-cycle scan of the
// N active buckets; the result is loaded once the response register is free.
// Reset restores 100 ms and 10 buckets and clears all slot valid bits.
`include "bucketed_window_rate_meter_defines.svh"

module bucketed_window_rate_meter
   import bwrm_pkg::*;
#(
   parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // now_ms
   input  logic                  req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // window_count, rate_per_second, zero fill
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [INTERVAL_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   bwrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bwrm_dpath #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `BWRM_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `BWRM_ASSERT_SAME(a_out_load_free, cmd.out_load, !rsp_tvalid || rsp_tready)
   `BWRM_ASSERT_SAME(a_write_on_record, cmd.mem_write, !sts.is_query)

endmodule
